// ===== hw/rtl/hrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrt_pkg: shared types and constants for the request header tokenizer
// Holds phase codes, token kinds, error codes and the front-to-back request.
// ----------------------------------------------------------------------------
package hrt_pkg;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_PATH    = 3'd1,
        PH_QUERY   = 3'd2,
        PH_VERSION = 3'd3,
        PH_TAIL    = 3'd4,
        PH_HEADER  = 3'd5,
        PH_BODY    = 3'd6,
        PH_DONE    = 3'd7
    } phase_t;

    localparam logic [3:0] KIND_DROP    = 4'd0;
    localparam logic [3:0] KIND_METHOD  = 4'd1;
    localparam logic [3:0] KIND_PATH    = 4'd2;
    localparam logic [3:0] KIND_QUERY   = 4'd3;
    localparam logic [3:0] KIND_VERSION = 4'd4;
    localparam logic [3:0] KIND_NAME    = 4'd5;
    localparam logic [3:0] KIND_VALUE   = 4'd6;
    localparam logic [3:0] KIND_HOST    = 4'd7;
    localparam logic [3:0] KIND_PORT    = 4'd8;
    localparam logic [3:0] KIND_BODY    = 4'd9;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_DONE    = 2'd1;
    localparam logic [1:0] ERR_NOCOLON = 2'd2;

    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_QMARK = 8'h3f;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    localparam int KEY_LEN_N  = 14;
    localparam int KEY_HOST_N = 4;

    // lower-case key characters
    function automatic logic [7:0] key_length_char(input logic [3:0] pos);
        logic [7:0] ch;
        begin
            case (pos)
                4'd0:    ch = "c";
                4'd1:    ch = "o";
                4'd2:    ch = "n";
                4'd3:    ch = "t";
                4'd4:    ch = "e";
                4'd5:    ch = "n";
                4'd6:    ch = "t";
                4'd7:    ch = "-";
                4'd8:    ch = "l";
                4'd9:    ch = "e";
                4'd10:   ch = "n";
                4'd11:   ch = "g";
                4'd12:   ch = "t";
                4'd13:   ch = "h";
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

    function automatic logic [7:0] key_host_char(input logic [3:0] pos);
        logic [7:0] ch;
        begin
            case (pos)
                4'd0:    ch = "h";
                4'd1:    ch = "o";
                4'd2:    ch = "s";
                4'd3:    ch = "t";
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

    // classified request from front to back
    typedef struct packed {
        logic       restart;
        logic [7:0] data;
        logic       is_cr;
        logic       is_lf;
        logic       is_sp;
        logic       is_blank;
        logic       is_qmark;
        logic       is_colon;
        logic       is_plus;
        logic       is_minus;
        logic       is_digit;
        logic [3:0] digit;
        logic [7:0] lower;
    } req_t;

endpackage

// ===== hw/rtl/hrt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrt_front: input stage
// Accepts requests, classifies the byte and pushes a request into the queue.
// ----------------------------------------------------------------------------
module hrt_front (
    input  logic          valid,
    output logic          ready,
    input  logic          op,
    input  logic [7:0]    data_byte,
    output logic          push,
    output hrt_pkg::req_t push_req,
    input  logic          q_full
);
    import hrt_pkg::*;

    logic [7:0] lc;

    // accept whenever the queue has room
    assign ready = !q_full;
    assign push  = valid && ready;

    // classify the byte
    always_comb
    begin
        lc = (data_byte inside {["A":"Z"]}) ? data_byte + 8'd32 : data_byte;
        push_req.restart  = op;
        push_req.data     = op ? 8'h00 : data_byte;
        push_req.is_cr    = (data_byte == CH_CR);
        push_req.is_lf    = (data_byte == CH_LF);
        push_req.is_sp    = (data_byte == CH_SP);
        push_req.is_blank = (data_byte == CH_SP) || (data_byte == CH_TAB);
        push_req.is_qmark = (data_byte == CH_QMARK);
        push_req.is_colon = (data_byte == CH_COLON);
        push_req.is_plus  = (data_byte == CH_PLUS);
        push_req.is_minus = (data_byte == CH_MINUS);
        push_req.is_digit = (data_byte inside {["0":"9"]});
        push_req.digit    = 4'(data_byte - 8'h30);
        push_req.lower    = lc;
    end

endmodule

// ===== hw/rtl/hrt_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrt_queue: two-entry request queue
// Decouples the input stage from the parse stage.
// ----------------------------------------------------------------------------
module hrt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hrt_pkg::req_t push_req,
    output logic          full,
    output logic          not_empty,
    input  logic          pop,
    output hrt_pkg::req_t head
);
    import hrt_pkg::*;

    req_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== hw/rtl/hrt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrt_back: parse stage
// Runs the tokenizer state and holds the result in an output register.
// ----------------------------------------------------------------------------
module hrt_back #(
    parameter int LENGTH_BITS = 31
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          host_split_enable,
    input  logic          not_empty,
    input  hrt_pkg::req_t head,
    output logic          pop,
    output logic          valid,
    input  logic          ready,
    output logic [7:0]    out_byte,
    output logic [3:0]    kind,
    output logic          token_start,
    output logic          length_ready,
    output logic [30:0]   content_length,
    output logic          headers_done,
    output logic [30:0]   body_left,
    output logic          complete,
    output logic [1:0]    error
);
    import hrt_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
    localparam int MW = LENGTH_BITS + 4;

    phase_t                 phase_reg, phase_next;
    logic                   als_reg, als_next;
    logic [3:0]             pos_reg, pos_next;
    logic                   islen_reg, islen_next;
    logic                   ishost_reg, ishost_next;
    logic                   vstart_reg, vstart_next;
    logic                   dstop_reg, dstop_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic                   colon_reg, colon_next;
    logic                   tok_reg, tok_next;
    logic                   port_reg, port_next;
    logic                   pend_reg, pend_next;
    logic [LENGTH_BITS-1:0] latch_reg, latch_next;

    logic                   ovalid_reg;
    logic [7:0]             obyte_reg;
    logic [3:0]             okind_reg;
    logic                   ots_reg, olr_reg, ohd_reg, ocmp_reg;
    logic [1:0]             oerr_reg;

    logic [3:0]             k;
    logic [1:0]             e;
    logic                   lr, hd;
    logic [MW-1:0]          prod;
    logic                   line_reset;

    // pop when output register is free or being drained
    assign pop   = not_empty && (!ovalid_reg || ready);
    assign valid = ovalid_reg;

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        als_next    = als_reg;
        pos_next    = pos_reg;
        islen_next  = islen_reg;
        ishost_next = ishost_reg;
        vstart_next = vstart_reg;
        dstop_next  = dstop_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        colon_next  = colon_reg;
        tok_next    = tok_reg;
        port_next   = port_reg;
        pend_next   = pend_reg;
        latch_next  = latch_reg;
        k           = KIND_DROP;
        e           = ERR_NONE;
        lr          = 1'b0;
        hd          = 1'b0;
        line_reset  = 1'b0;
        prod        = MW'(acc_reg) * MW'(10) + MW'(head.digit);

        if (head.restart)
        begin
            phase_next  = PH_METHOD;
            line_reset  = 1'b1;
            rem_next    = '0;
            latch_next  = '0;
        end
        else if (phase_reg == PH_DONE)
        begin
            e = ERR_DONE;
        end
        else if (phase_reg == PH_BODY)
        begin
            k = KIND_BODY;
            if (rem_reg <= LENGTH_BITS'(1))
            begin
                rem_next   = '0;
                phase_next = PH_DONE;
            end
            else
                rem_next = rem_reg - LENGTH_BITS'(1);
        end
        else if (head.is_cr)
        begin
        end
        else if (phase_reg inside {PH_METHOD, PH_PATH, PH_QUERY, PH_VERSION, PH_TAIL})
        begin
            if (head.is_lf)
            begin
                phase_next = PH_HEADER;
                line_reset = 1'b1;
            end
            else if (head.is_sp)
            begin
                case (phase_reg)
                    PH_METHOD: phase_next = PH_PATH;
                    PH_VERSION, PH_TAIL: phase_next = PH_TAIL;
                    default: phase_next = PH_VERSION;
                endcase
                tok_next = 1'b0;
            end
            else if (head.is_qmark && phase_reg == PH_PATH)
            begin
                phase_next = PH_QUERY;
                tok_next   = 1'b0;
            end
            else if (phase_reg != PH_TAIL)
            begin
                k = 4'({1'b0, phase_reg} + 4'd1);
            end
        end
        else if (head.is_lf)
        begin
            if (als_reg)
            begin
                hd         = 1'b1;
                phase_next = (rem_reg != '0) ? PH_BODY : PH_DONE;
                tok_next   = 1'b0;
            end
            else
            begin
                if (!colon_reg)
                    e = ERR_NOCOLON;
                else if (islen_reg)
                begin
                    latch_next = acc_reg;
                    rem_next   = acc_reg;
                    lr         = 1'b1;
                end
                line_reset = 1'b1;
            end
        end
        else if (!colon_reg)
        begin
            als_next = 1'b0;
            if (head.is_colon)
            begin
                islen_next  = islen_reg && pos_reg == 4'(KEY_LEN_N);
                ishost_next = ishost_reg && pos_reg == 4'(KEY_HOST_N) && host_split_enable;
                colon_next  = 1'b1;
                tok_next    = 1'b0;
            end
            else if (head.is_blank)
            begin
                pend_next = 1'b1;
            end
            else
            begin
                k = KIND_NAME;
                if (pend_reg || pos_reg >= 4'(KEY_LEN_N)
                    || head.lower != key_length_char(pos_reg))
                    islen_next = 1'b0;
                if (pend_reg || pos_reg >= 4'(KEY_HOST_N)
                    || head.lower != key_host_char(pos_reg))
                    ishost_next = 1'b0;
                if (pos_reg < 4'd15)
                    pos_next = pos_reg + 4'd1;
            end
        end
        else if (!vstart_reg && head.is_blank)
        begin
        end
        else
        begin
            if (islen_reg)
            begin
                if (!vstart_reg && head.is_plus)
                begin
                end
                else if (!vstart_reg && head.is_minus)
                    dstop_next = 1'b1;
                else if (!dstop_reg)
                begin
                    if (head.is_digit)
                        acc_next = (prod > MW'(LEN_MAX)) ? LEN_MAX
                                                         : prod[LENGTH_BITS-1:0];
                    else
                        dstop_next = 1'b1;
                end
            end
            vstart_next = 1'b1;
            if (ishost_reg)
            begin
                if (!port_reg && head.is_colon)
                begin
                    port_next = 1'b1;
                    tok_next  = 1'b0;
                end
                else
                    k = port_reg ? KIND_PORT : KIND_HOST;
            end
            else
                k = KIND_VALUE;
        end

        // start of a new header line, or a restart
        if (line_reset)
        begin
            als_next    = 1'b1;
            colon_next  = 1'b0;
            pos_next    = '0;
            islen_next  = !head.restart;
            ishost_next = !head.restart;
            pend_next   = 1'b0;
            tok_next    = 1'b0;
            port_next   = 1'b0;
            vstart_next = 1'b0;
            dstop_next  = 1'b0;
            acc_next    = '0;
        end

        if (k != KIND_DROP)
            tok_next = 1'b1;
    end

    // tokenizer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_METHOD;
            als_reg    <= 1'b1;
            pos_reg    <= '0;
            islen_reg  <= 1'b0;
            ishost_reg <= 1'b0;
            vstart_reg <= 1'b0;
            dstop_reg  <= 1'b0;
            acc_reg    <= '0;
            rem_reg    <= '0;
            colon_reg  <= 1'b0;
            tok_reg    <= 1'b0;
            port_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            latch_reg  <= '0;
        end
        else if (pop)
        begin
            phase_reg  <= phase_next;
            als_reg    <= als_next;
            pos_reg    <= pos_next;
            islen_reg  <= islen_next;
            ishost_reg <= ishost_next;
            vstart_reg <= vstart_next;
            dstop_reg  <= dstop_next;
            acc_reg    <= acc_next;
            rem_reg    <= rem_next;
            colon_reg  <= colon_next;
            tok_reg    <= tok_next;
            port_reg   <= port_next;
            pend_reg   <= pend_next;
            latch_reg  <= latch_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (pop)
            ovalid_reg <= 1'b1;
        else if (ready)
            ovalid_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            obyte_reg <= head.data;
            okind_reg <= k;
            ots_reg   <= (k != KIND_DROP) && !tok_reg;
            olr_reg   <= lr;
            ohd_reg   <= hd;
            ocmp_reg  <= (phase_next == PH_DONE);
            oerr_reg  <= e;
            content_length <= 31'(latch_next);
            body_left      <= 31'(rem_next);
        end
    end

    assign out_byte     = obyte_reg;
    assign kind         = okind_reg;
    assign token_start  = ots_reg;
    assign length_ready = olr_reg;
    assign headers_done = ohd_reg;
    assign complete     = ocmp_reg;
    assign error        = oerr_reg;

endmodule

// ===== hw/rtl/http_request_header_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_header_tokenizer_unit: byte-wise HTTP request tokenizer
// Tags each request byte, decodes content-length and counts the body.
//
//   channel  signals                          direction
//   cfg      cfg_valid/cfg_ready, cfg_data    in   host split enable
//   in       in_valid/in_ready, op, data_byte in   one byte or restart
//   out      out_valid/out_ready, result      out  one result per request
//
// One byte per cycle while the output is not stalled; bytes pass the queue and the output register.
// The parse stage updates all token state for each byte that it pops.
// Reset clears the pointers, token state and output valid; the split enable resets to zero.
// A stalled output holds the result while the two-entry queue keeps taking until full.
// ----------------------------------------------------------------------------
module http_request_header_tokenizer_unit #(
    parameter int LENGTH_BITS = 31
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [3:0]  kind,
    output logic        token_start,
    output logic        length_ready,
    output logic [30:0] content_length,
    output logic        headers_done,
    output logic [30:0] body_left,
    output logic        complete,
    output logic [1:0]  error
);
    import hrt_pkg::*;

    logic  split_reg;
    logic  push, q_full, q_ne, pop;
    req_t  push_req, head;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            split_reg <= 1'b0;
        else if (cfg_valid)
            split_reg <= cfg_data;
    end

    hrt_front u_front (
        .valid     (in_valid),
        .ready     (in_ready),
        .op        (op),
        .data_byte (data_byte),
        .push      (push),
        .push_req  (push_req),
        .q_full    (q_full)
    );

    hrt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_req  (push_req),
        .full      (q_full),
        .not_empty (q_ne),
        .pop       (pop),
        .head      (head)
    );

    hrt_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .host_split_enable (split_reg),
        .not_empty         (q_ne),
        .head              (head),
        .pop               (pop),
        .valid             (out_valid),
        .ready             (out_ready),
        .out_byte          (out_byte),
        .kind              (kind),
        .token_start       (token_start),
        .length_ready      (length_ready),
        .content_length    (content_length),
        .headers_done      (headers_done),
        .body_left         (body_left),
        .complete          (complete),
        .error             (error)
    );

endmodule
